[src/smp_pkg.sv]
// Shared types, constants and a saturation helper function for the similarity morph point block.
package smp_pkg;

    // Table depth default
    localparam int POINTS_DEFAULT = 64;

    // Field widths
    localparam int IDX_W      = 6;
    localparam int COORD_W    = 18;
    localparam int PROG_W     = 16;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;
    localparam int PAIR_W     = 4 * COORD_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOG_SCALE = 3'd0,
        CFG_ROT_ANGLE = 3'd1,
        CFG_SRC_CX    = 3'd2,
        CFG_SRC_CY    = 3'd3,
        CFG_TGT_CX    = 3'd4,
        CFG_TGT_CY    = 3'd5
    } t_cfg_idx;

    // Progress clamp, Q2.14
    localparam logic signed [PROG_W-1:0] P_MIN = -16'sd4096;
    localparam logic signed [PROG_W-1:0] P_MAX = 16'sd20480;

    // Q.28 constants, and log2(e) in Q16
    localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;
    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic [27:0]        LN2_Q28     = 28'd186065279;
    localparam logic signed [17:0] LOG2E_Q16   = 18'sd94548;

    // Horner chains: divisors n*(n-1) for sin/cos, n for exp
    localparam int CELL_LAT  = 3;
    localparam int SIN_CELLS = 5;
    localparam int COS_CELLS = 6;
    localparam int EXP_CELLS = 7;
    localparam int SIN_DIV [SIN_CELLS] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_CELLS] = '{132, 90, 56, 30, 12, 2};
    localparam int EXP_DIV [EXP_CELLS] = '{7, 6, 5, 4, 3, 2, 1};

    // Data that rides alongside the Horner chains
    typedef struct packed {
        logic signed [19:0] rx;
        logic signed [19:0] ry;
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic signed [31:0] a;
        logic               neg_cos;
        logic signed [5:0]  k;
    } t_side;

    // Saturate to the 18-bit coordinate range
    function automatic logic signed [COORD_W-1:0] sat18(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 64'sd131071) begin
            res = 18'sd131071;
        end else if (v < -64'sd131072) begin
            res = -18'sd131072;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/smp_ram.sv]
// Generic simple dual-port RAM with registered read.
module smp_ram #(
    parameter int WIDTH = smp_pkg::PAIR_W,
    parameter int DEPTH = smp_pkg::POINTS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/smp_horner_cell.sv]
// One Horner step cell: acc' = 1 -/+ (acc*x >> 28) / DIVISOR, three register stages.
module smp_horner_cell #(
    parameter int DIVISOR  = smp_pkg::SIN_DIV[0],
    parameter bit EXP_MODE = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_acc,
    input  logic signed [31:0] i_x,
    output logic signed [31:0] o_acc,
    output logic signed [31:0] o_x
);

    // floor(2^32 / DIVISOR); quotient estimate is exact or one low
    localparam logic [32:0] RECIP = 33'((65'd1 << 32) / DIVISOR);
    localparam logic [39:0] DIV_C = 40'(DIVISOR);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_xa, r_xb, r_xc;
    logic [64:0]        r_mq;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic signed [31:0] r_acc;

    logic signed [35:0] w_q;
    logic               w_neg;
    logic [31:0]        w_mag;
    logic [31:0]        w_q0;
    logic [39:0]        w_rem;
    logic [31:0]        w_q1;
    logic signed [31:0] w_quo;

    // stage B: scale back to Q.28 and take the magnitude
    always_comb begin
        if (EXP_MODE) begin
            w_q = 36'(r_prod >>> 28);
        end else begin
            w_q = 36'((r_prod + 64'sd134217728) >>> 28);
        end
        w_neg = w_q[35];
        w_mag = w_neg ? 32'(-w_q) : 32'(w_q);
    end

    // stage C: fix the reciprocal estimate, truncate toward zero
    always_comb begin
        w_q0  = r_mq[63:32];
        w_rem = 40'(r_mag) - 40'(w_q0) * DIV_C;
        w_q1  = (w_rem >= DIV_C) ? w_q0 + 32'd1 : w_q0;
        w_quo = r_neg ? -$signed(w_q1) : $signed(w_q1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_acc * i_x;
            r_xa   <= i_x;
            r_mq   <= 65'(w_mag) * 65'(RECIP);
            r_mag  <= w_mag;
            r_neg  <= w_neg;
            r_xb   <= r_xa;
            r_acc  <= EXP_MODE ? smp_pkg::ONE_Q28 + w_quo : smp_pkg::ONE_Q28 - w_quo;
            r_xc   <= r_xb;
        end
    end

    assign o_acc = r_acc;
    assign o_x   = r_xc;

endmodule

[src/similarity_morph_point.sv]
// Top level of the similarity morph point pipeline.
// Load transfers (tuser = 0) write a source/target residual pair into a POINTS-entry table;
// resolve transfers (tuser = 1) read one pair, clamp progress to -0.25..1.25, interpolate the
// residual and the centers, rotate by angle*progress and scale by exp(log_scale*progress),
// giving one saturated Q10.8 point per resolve. The block takes one transfer per clock; the
// pipeline depth is set by the polynomial Horner cell chains for sine, cosine and the
// exponential (three stages per cell, seven exp cells). An output register plus a skid
// register let input flow on while a result waits; input stalls only when both are full.
// Table entries are undefined until loaded. Config writes belong in idle periods.
module similarity_morph_point #(
    parameter int POINTS = smp_pkg::POINTS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // point_index[5:0], source_x[23:6], source_y[41:24], target_x[59:42],
    // target_y[77:60], progress[93:78], zero pad[95:94]
    input  logic [smp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode[0]: 0 load, 1 resolve
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // point_x[17:0], point_y[35:18], zero pad[39:36]
    output logic [smp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [smp_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [smp_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int AW       = $clog2(POINTS);
    localparam int ST_CELL  = 5;
    localparam int ST_SIN   = ST_CELL + smp_pkg::CELL_LAT * smp_pkg::SIN_CELLS;
    localparam int ST_COS   = ST_CELL + smp_pkg::CELL_LAT * smp_pkg::COS_CELLS;
    localparam int ST_EXP   = ST_CELL + smp_pkg::CELL_LAT * smp_pkg::EXP_CELLS;
    localparam int ST_LAST  = ST_EXP + 2;

    // configuration registers
    logic signed [15:0] r_log_scale, r_rot_angle;
    logic signed [17:0] r_scx, r_scy, r_tcx, r_tcy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_scale <= '0;
            r_rot_angle <= '0;
            r_scx       <= '0;
            r_scy       <= '0;
            r_tcx       <= '0;
            r_tcy       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                smp_pkg::CFG_LOG_SCALE: r_log_scale <= i_cfg_wdata[15:0];
                smp_pkg::CFG_ROT_ANGLE: r_rot_angle <= i_cfg_wdata[15:0];
                smp_pkg::CFG_SRC_CX:    r_scx       <= i_cfg_wdata;
                smp_pkg::CFG_SRC_CY:    r_scy       <= i_cfg_wdata;
                smp_pkg::CFG_TGT_CX:    r_tcx       <= i_cfg_wdata;
                smp_pkg::CFG_TGT_CY:    r_tcy       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake and stall
    logic en, accept;
    logic r_skid_valid, r_out_valid;
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // point table: {ty, tx, sy, sx}
    logic [smp_pkg::PAIR_W-1:0] w_pair;
    logic [AW-1:0]              w_addr;
    assign w_addr = AW'(s_axis_tdata[5:0]);

    smp_ram #(
        .WIDTH(smp_pkg::PAIR_W),
        .DEPTH(POINTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (accept && !s_axis_tuser),
        .i_waddr(w_addr),
        .i_wdata(s_axis_tdata[77:6]),
        .i_re   (en),
        .i_raddr(w_addr),
        .o_rdata(w_pair)
    );

    // valid line for resolve items
    logic [ST_LAST:1] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[ST_LAST-1:1], accept && s_axis_tuser};
        end
    end

    // stage 1: clamp progress
    logic signed [15:0] w_prog, r1_p;
    assign w_prog = s_axis_tdata[93:78];

    // stage 2: interpolation and angle/scale products
    logic signed [17:0] w_sx, w_sy, w_tx, w_ty;
    logic signed [18:0] w_dx, w_dy, w_dcx, w_dcy;
    logic signed [17:0] r2_sx, r2_sy, r2_scx, r2_scy;
    logic signed [35:0] r2_pdx, r2_pdy, r2_pcx, r2_pcy;
    logic signed [31:0] r2_pth, r2_pls;

    assign w_sx  = w_pair[17:0];
    assign w_sy  = w_pair[35:18];
    assign w_tx  = w_pair[53:36];
    assign w_ty  = w_pair[71:54];
    assign w_dx  = 19'(w_tx) - 19'(w_sx);
    assign w_dy  = 19'(w_ty) - 19'(w_sy);
    assign w_dcx = 19'(r_tcx) - 19'(r_scx);
    assign w_dcy = 19'(r_tcy) - 19'(r_scy);

    // stage 3: round, reduce and fold the angle, base-2 exponent
    logic signed [17:0] w_a13, w_ls;
    logic signed [32:0] w_a28, w_ar1, w_ar2, w_af;
    logic               w_negc;
    logic signed [19:0] r3_rx, r3_ry, r3_cx, r3_cy;
    logic signed [31:0] r3_a;
    logic               r3_negc;
    logic signed [35:0] r3_e;

    always_comb begin
        w_a13 = 18'((r2_pth + 32'sd8192) >>> 14);
        w_ls  = 18'((r2_pls + 32'sd8192) >>> 14);
        w_a28 = 33'(w_a13) <<< 15;
        w_ar1 = (w_a28 > smp_pkg::PI_Q28) ? w_a28 - smp_pkg::TWO_PI_Q28 : w_a28;
        w_ar2 = (w_ar1 < -smp_pkg::PI_Q28) ? w_ar1 + smp_pkg::TWO_PI_Q28 : w_ar1;
        if (w_ar2 > smp_pkg::HALF_PI_Q28) begin
            w_af   = smp_pkg::PI_Q28 - w_ar2;
            w_negc = 1'b1;
        end else if (w_ar2 < -smp_pkg::HALF_PI_Q28) begin
            w_af   = -smp_pkg::PI_Q28 - w_ar2;
            w_negc = 1'b1;
        end else begin
            w_af   = w_ar2;
            w_negc = 1'b0;
        end
    end

    // stage 4: a^2 and fractional exponent product
    logic signed [63:0] r4_asq;
    logic [55:0]        r4_fl;
    smp_pkg::t_side     r4_side;

    // stage 5: Horner inputs
    logic signed [31:0] r5_a2;
    logic [27:0]        r5_u;
    smp_pkg::t_side     r_side [ST_LAST:ST_CELL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p   <= (w_prog < smp_pkg::P_MIN) ? smp_pkg::P_MIN :
                      (w_prog > smp_pkg::P_MAX) ? smp_pkg::P_MAX : w_prog;
            r2_sx  <= w_sx;
            r2_sy  <= w_sy;
            r2_scx <= r_scx;
            r2_scy <= r_scy;
            r2_pdx <= w_dx * r1_p;
            r2_pdy <= w_dy * r1_p;
            r2_pcx <= w_dcx * r1_p;
            r2_pcy <= w_dcy * r1_p;
            r2_pth <= r_rot_angle * r1_p;
            r2_pls <= r_log_scale * r1_p;
            r3_rx  <= 20'(r2_sx) + 20'((r2_pdx + 36'sd8192) >>> 14);
            r3_ry  <= 20'(r2_sy) + 20'((r2_pdy + 36'sd8192) >>> 14);
            r3_cx  <= 20'(r2_scx) + 20'((r2_pcx + 36'sd8192) >>> 14);
            r3_cy  <= 20'(r2_scy) + 20'((r2_pcy + 36'sd8192) >>> 14);
            r3_a   <= 32'(w_af);
            r3_negc <= w_negc;
            r3_e   <= w_ls * smp_pkg::LOG2E_Q16;
            r4_asq <= r3_a * r3_a;
            r4_fl  <= 56'(r3_e[27:0]) * 56'(smp_pkg::LN2_Q28);
            r4_side.rx      <= r3_rx;
            r4_side.ry      <= r3_ry;
            r4_side.cx      <= r3_cx;
            r4_side.cy      <= r3_cy;
            r4_side.a       <= r3_a;
            r4_side.neg_cos <= r3_negc;
            r4_side.k       <= r3_e[33:28];
            r5_a2  <= 32'((r4_asq + 64'sd134217728) >>> 28);
            r5_u   <= r4_fl[55:28];
            r_side[ST_CELL] <= r4_side;
            for (int i = ST_CELL + 1; i <= ST_LAST; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Horner cell chains
    logic signed [31:0] w_sin_acc [smp_pkg::SIN_CELLS+1];
    logic signed [31:0] w_sin_x   [smp_pkg::SIN_CELLS+1];
    logic signed [31:0] w_cos_acc [smp_pkg::COS_CELLS+1];
    logic signed [31:0] w_cos_x   [smp_pkg::COS_CELLS+1];
    logic signed [31:0] w_exp_acc [smp_pkg::EXP_CELLS+1];
    logic signed [31:0] w_exp_x   [smp_pkg::EXP_CELLS+1];

    assign w_sin_acc[0] = smp_pkg::ONE_Q28;
    assign w_sin_x[0]   = r5_a2;
    assign w_cos_acc[0] = smp_pkg::ONE_Q28;
    assign w_cos_x[0]   = r5_a2;
    assign w_exp_acc[0] = smp_pkg::ONE_Q28;
    assign w_exp_x[0]   = 32'(r5_u);

    for (genvar g = 0; g < smp_pkg::SIN_CELLS; g++) begin : g_sin
        smp_horner_cell #(.DIVISOR(smp_pkg::SIN_DIV[g]), .EXP_MODE(1'b0)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_acc(w_sin_acc[g]), .i_x(w_sin_x[g]),
            .o_acc(w_sin_acc[g+1]), .o_x(w_sin_x[g+1])
        );
    end

    for (genvar g = 0; g < smp_pkg::COS_CELLS; g++) begin : g_cos
        smp_horner_cell #(.DIVISOR(smp_pkg::COS_DIV[g]), .EXP_MODE(1'b0)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_acc(w_cos_acc[g]), .i_x(w_cos_x[g]),
            .o_acc(w_cos_acc[g+1]), .o_x(w_cos_x[g+1])
        );
    end

    for (genvar g = 0; g < smp_pkg::EXP_CELLS; g++) begin : g_exp
        smp_horner_cell #(.DIVISOR(smp_pkg::EXP_DIV[g]), .EXP_MODE(1'b1)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_acc(w_exp_acc[g]), .i_x(w_exp_x[g]),
            .o_acc(w_exp_acc[g+1]), .o_x(w_exp_x[g+1])
        );
    end

    // back end: sine, rotation, scale
    logic signed [63:0] r21_sprod;
    logic signed [31:0] r22_sn, r23_sn;
    logic signed [31:0] w_cs;
    logic signed [55:0] r24_xc, r24_ys, r24_xs, r24_yc;
    logic signed [35:0] r25_uu, r25_vv, r26_uu, r26_vv;
    logic signed [23:0] w_m20;
    logic signed [41:0] r27_ulo, r27_uhi, r27_vlo, r27_vhi;
    logic signed [63:0] r28_uf, r28_vf;

    assign w_cs  = r_side[ST_COS].neg_cos ? -w_cos_acc[smp_pkg::COS_CELLS]
                                          : w_cos_acc[smp_pkg::COS_CELLS];
    assign w_m20 = 24'((w_exp_acc[smp_pkg::EXP_CELLS] + 32'sd128) >>> 8);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r21_sprod <= w_sin_acc[smp_pkg::SIN_CELLS] * r_side[ST_SIN].a;
            r22_sn    <= 32'((r21_sprod + 64'sd134217728) >>> 28);
            r23_sn    <= r22_sn;
            r24_xc    <= r_side[ST_COS].rx * w_cs;
            r24_ys    <= r_side[ST_COS].ry * r23_sn;
            r24_xs    <= r_side[ST_COS].rx * r23_sn;
            r24_yc    <= r_side[ST_COS].ry * w_cs;
            r25_uu    <= 36'((r24_xc - r24_ys + 56'sd8192) >>> 14);
            r25_vv    <= 36'((r24_xs + r24_yc + 56'sd8192) >>> 14);
            r26_uu    <= r25_uu;
            r26_vv    <= r25_vv;
            // split the residual so each multiplier stays narrow
            r27_ulo   <= $signed({1'b0, r26_uu[16:0]}) * w_m20;
            r27_uhi   <= $signed(r26_uu[35:17]) * w_m20;
            r27_vlo   <= $signed({1'b0, r26_vv[16:0]}) * w_m20;
            r27_vhi   <= $signed(r26_vv[35:17]) * w_m20;
            r28_uf    <= (64'(r27_uhi) <<< 17) + 64'(r27_ulo);
            r28_vf    <= (64'(r27_vhi) <<< 17) + 64'(r27_vlo);
        end
    end

    // final: round by 2^(34-k), add center, saturate
    logic signed [7:0]  w_shs;
    logic [5:0]         w_sh;
    logic signed [63:0] w_half, w_ush, w_vsh;
    logic signed [17:0] w_px, w_py;
    logic [smp_pkg::OUT_DATA_W-1:0] w_res;

    always_comb begin
        w_shs  = 8'sd34 - 8'(r_side[ST_LAST].k);
        w_sh   = w_shs[5:0];
        w_half = 64'sd1 <<< (w_sh - 6'd1);
        w_ush  = (r28_uf + w_half) >>> w_sh;
        w_vsh  = (r28_vf + w_half) >>> w_sh;
        w_px   = smp_pkg::sat18(64'(r_side[ST_LAST].cx) + w_ush);
        w_py   = smp_pkg::sat18(64'(r_side[ST_LAST].cy) + w_vsh);
        w_res  = {4'b0, w_py, w_px};
    end

    // output register plus skid register
    logic w_new_valid;
    logic [smp_pkg::OUT_DATA_W-1:0] r_out_data, r_skid_data;
    assign w_new_valid = r_v[ST_LAST] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_data  <= w_res;
                r_out_valid <= w_new_valid;
            end
        end else if (w_new_valid) begin
            r_skid_data  <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data while output register is empty");

    a_resolve_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_v[1] == $past(s_axis_tuser)))
        else $error("accepted transfer did not enter the valid line correctly");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid register filled while output was free");

endmodule

[bench/tb_similarity_morph_point.sv]
// Testbench for the similarity morph point block: directed and random load/resolve traffic.
`timescale 1ns / 1ps

module tb_similarity_morph_point;

    localparam int  LATENCY   = 29;
    localparam int  WDOG_MAX  = 20000;
    localparam longint Q28    = 64'sd268435456;
    localparam longint PI28   = 64'sd843314857;
    localparam longint TWOPI28 = 64'sd1686629713;
    localparam longint HPI28  = 64'sd421657428;
    localparam longint LN2_28 = 64'sd186065279;
    localparam longint LOG2E  = 64'sd94548;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
    } t_point;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [smp_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [smp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            i_cfg_we;
    logic [smp_pkg::CFG_IDX_W-1:0]   i_cfg_addr;
    logic [smp_pkg::CFG_W-1:0]       i_cfg_wdata;

    // Shadow of the configuration and the point tables
    longint  cfg_shadow [6];
    longint  src_x_tab [64], src_y_tab [64], tgt_x_tab [64], tgt_y_tab [64];
    bit      loaded [64];
    t_point  pending_points [$];

    int  errors;
    int  idle_pct;
    int  stall_pct;
    int  wdog;

    similarity_morph_point dut (.*);

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Fixed-point helpers
    function automatic longint round_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    // Predict one resolved point from table entry and progress
    function automatic t_point resolve_point(int idx, longint prog);
        longint p, rx, ry, cx, cy, a, a2, acc, sn, cs, e, kk, f, u, m20, uu, vv;
        longint scx, scy, tcx, tcy;
        bit neg_cos;
        t_point res;
        p = prog;
        if (p < -4096) p = -4096;
        if (p > 20480) p = 20480;
        scx = cfg_shadow[smp_pkg::CFG_SRC_CX];
        scy = cfg_shadow[smp_pkg::CFG_SRC_CY];
        tcx = cfg_shadow[smp_pkg::CFG_TGT_CX];
        tcy = cfg_shadow[smp_pkg::CFG_TGT_CY];
        rx = src_x_tab[idx] + round_shr((tgt_x_tab[idx] - src_x_tab[idx]) * p, 14);
        ry = src_y_tab[idx] + round_shr((tgt_y_tab[idx] - src_y_tab[idx]) * p, 14);
        cx = scx + round_shr((tcx - scx) * p, 14);
        cy = scy + round_shr((tcy - scy) * p, 14);
        // sine / cosine
        a = round_shr(cfg_shadow[smp_pkg::CFG_ROT_ANGLE] * p, 14) * 32768;
        neg_cos = 0;
        if (a > PI28) a -= TWOPI28;
        if (a < -PI28) a += TWOPI28;
        if (a > HPI28) begin
            a = PI28 - a;
            neg_cos = 1;
        end else if (a < -HPI28) begin
            a = -PI28 - a;
            neg_cos = 1;
        end
        a2 = round_shr(a * a, 28);
        acc = Q28;
        for (int n = 11; n >= 3; n -= 2)
            acc = Q28 - round_shr(acc * a2, 28) / (n * (n - 1));
        sn = round_shr(acc * a, 28);
        acc = Q28;
        for (int n = 12; n >= 2; n -= 2)
            acc = Q28 - round_shr(acc * a2, 28) / (n * (n - 1));
        cs = neg_cos ? -acc : acc;
        // scale as 2^k * 2^f
        e = round_shr(cfg_shadow[smp_pkg::CFG_LOG_SCALE] * p, 14) * LOG2E;
        kk = e >>> 28;
        f = e - kk * Q28;
        u = (f * LN2_28) >>> 28;
        acc = Q28;
        for (int n = 7; n >= 1; n--)
            acc = Q28 + ((acc * u) >>> 28) / n;
        m20 = round_shr(acc, 8);
        uu = round_shr(rx * cs - ry * sn, 14);
        vv = round_shr(rx * sn + ry * cs, 14);
        res.x = 18'(sat_coord(cx + round_shr(uu * m20, int'(34 - kk))));
        res.y = 18'(sat_coord(cy + round_shr(vv * m20, int'(34 - kk))));
        return res;
    endfunction

    // Config write, only while idle; write enable stays up until cfg_done
    task automatic write_reg(smp_pkg::t_cfg_idx idx, longint val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[smp_pkg::CFG_W-1:0];
        @(posedge i_clk);
        cfg_shadow[idx] = (idx <= smp_pkg::CFG_ROT_ANGLE) ? longint'(signed'(val[15:0]))
                                                          : longint'(signed'(val[17:0]));
    endtask

    // End of a group of config writes
    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    // Send one item and update the prediction on acceptance
    task automatic send_item(bit mode, int idx, longint sx, longint sy, longint tx,
                             longint ty, longint prog);
        logic [smp_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[5:0]   = idx[5:0];
        d[23:6]  = sx[17:0];
        d[41:24] = sy[17:0];
        d[59:42] = tx[17:0];
        d[77:60] = ty[17:0];
        d[93:78] = prog[15:0];
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!mode) begin
            src_x_tab[idx] = longint'(signed'(sx[17:0]));
            src_y_tab[idx] = longint'(signed'(sy[17:0]));
            tgt_x_tab[idx] = longint'(signed'(tx[17:0]));
            tgt_y_tab[idx] = longint'(signed'(ty[17:0]));
            loaded[idx] = 1;
        end else begin
            pending_points.push_back(resolve_point(idx, longint'(signed'(prog[15:0]))));
        end
    endtask

    // Stop sending, wait for the pipeline to drain, then its latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic longint rnd_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 131071 : -131072;
            1: return longint'($urandom_range(2047)) - 1024;
            default: return longint'($urandom_range(262143)) - 131072;
        endcase
    endfunction

    function automatic longint rnd_prog();
        case ($urandom_range(3))
            0: return longint'($urandom_range(65535)) - 32768;
            default: return longint'($urandom_range(24576)) - 4096;
        endcase
    endfunction

    task automatic load_rand(int idx);
        send_item(1'b0, idx, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  longint'($urandom_range(65535)) - 32768);
    endtask

    // Directed: extreme coordinates, progress clamps, saturation
    task automatic test_directed();
        write_reg(smp_pkg::CFG_LOG_SCALE, 0);
        write_reg(smp_pkg::CFG_ROT_ANGLE, 0);
        write_reg(smp_pkg::CFG_SRC_CX, 0);
        write_reg(smp_pkg::CFG_SRC_CY, 0);
        write_reg(smp_pkg::CFG_TGT_CX, 0);
        write_reg(smp_pkg::CFG_TGT_CY, 0);
        cfg_done();
        send_item(1'b0, 0, 131071, -131072, -131072, 131071, 0);
        send_item(1'b0, 63, 256, -256, 512, 1024, 16'sh7fff);
        send_item(1'b0, 5, 0, 0, 0, 0, -32768);
        send_item(1'b1, 0, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0, 16384);
        send_item(1'b1, 0, 0, 0, 0, 0, -32768);
        send_item(1'b1, 0, 0, 0, 0, 0, 32767);
        send_item(1'b1, 63, 0, 0, 0, 0, 8192);
        send_item(1'b1, 5, 0, 0, 0, 0, 4096);
        drain();
        // max scale and angle: saturating outputs
        write_reg(smp_pkg::CFG_LOG_SCALE, 32767);
        write_reg(smp_pkg::CFG_ROT_ANGLE, 25736);
        write_reg(smp_pkg::CFG_SRC_CX, 131071);
        write_reg(smp_pkg::CFG_SRC_CY, -131072);
        write_reg(smp_pkg::CFG_TGT_CX, -131072);
        write_reg(smp_pkg::CFG_TGT_CY, 131071);
        cfg_done();
        send_item(1'b1, 0, 0, 0, 0, 0, 20480);
        send_item(1'b1, 63, 0, 0, 0, 0, -4096);
        send_item(1'b1, 63, 0, 0, 0, 0, 16384);
        send_item(1'b1, 0, 0, 0, 0, 0, 10000);
        drain();
        write_reg(smp_pkg::CFG_LOG_SCALE, -32768);
        write_reg(smp_pkg::CFG_ROT_ANGLE, -25736);
        cfg_done();
        send_item(1'b1, 0, 0, 0, 0, 0, 20480);
        send_item(1'b1, 63, 0, 0, 0, 0, -4096);
        send_item(1'b1, 5, 0, 0, 0, 0, 12000);
        drain();
    endtask

    // Random phases under several config settings and idle and stall profiles
    task automatic test_random(int items, int idle, int stall);
        int idx;
        idle_pct  = idle;
        stall_pct = stall;
        write_reg(smp_pkg::CFG_LOG_SCALE, longint'($urandom_range(65535)) - 32768);
        write_reg(smp_pkg::CFG_ROT_ANGLE, longint'($urandom_range(51472)) - 25736);
        write_reg(smp_pkg::CFG_SRC_CX, rnd_coord());
        write_reg(smp_pkg::CFG_SRC_CY, rnd_coord());
        write_reg(smp_pkg::CFG_TGT_CX, rnd_coord());
        write_reg(smp_pkg::CFG_TGT_CY, rnd_coord());
        if ($urandom_range(1))
            write_reg(smp_pkg::CFG_LOG_SCALE, longint'($urandom_range(8191)) - 4096);
        cfg_done();
        for (int i = 0; i < items; i++) begin
            idx = $urandom_range(63);
            if (!loaded[idx] || $urandom_range(99) < 30) load_rand(idx);
            else send_item(1'b1, idx, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                           rnd_prog());
        end
        drain();
    endtask

    // Random receiver stall
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result: point_x=%0d point_y=%0d",
                       $signed(m_axis_tdata[17:0]), $signed(m_axis_tdata[35:18]));
                errors++;
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_axis_tdata[17:0] !== exp_pt.x) begin
                    $error("point_x expected %0d actual %0d", exp_pt.x,
                           $signed(m_axis_tdata[17:0]));
                    errors++;
                end
                if (m_axis_tdata[35:18] !== exp_pt.y) begin
                    $error("point_y expected %0d actual %0d", exp_pt.y,
                           $signed(m_axis_tdata[35:18]));
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0;
        wdog = 0;
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 6; i++) cfg_shadow[i] = 0;
        for (int i = 0; i < 64; i++) loaded[i] = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b1;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= smp_pkg::CFG_LOG_SCALE;
        i_cfg_wdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(130, 0, 0);
        test_random(120, 54, 0);
        test_random(120, 0, 54);
        test_random(120, 21, 21);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
